[src/csv_stream_tokenizer_macros.svh]
// Assertion macros for the CSV stream tokenizer.
`ifndef CSV_STREAM_TOKENIZER_MACROS_SVH
`define CSV_STREAM_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define CST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/cst_pkg.sv]
// Shared types and constants of the CSV stream tokenizer.
package cst_pkg;

	localparam int ADDR_W = 4;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_DELIMITER = 2'd0;
	localparam logic [1:0] REG_STRICT    = 2'd1;
	localparam logic [1:0] REG_HEADERS   = 2'd2;

	// parse phases
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_UNQ    = 2'd1;
	localparam logic [1:0] PH_QUOTED = 2'd2;
	localparam logic [1:0] PH_AFTER  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_CONTENT = 2'd0;
	localparam logic [1:0] KIND_FIELD   = 2'd1;
	localparam logic [1:0] KIND_ROW     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_STRAY_QUOTE = 3'd1;
	localparam logic [2:0] ERR_AFTER_QUOTE = 3'd2;
	localparam logic [2:0] ERR_EMPTY_ROW   = 3'd3;
	localparam logic [2:0] ERR_FIELD_COUNT = 3'd4;
	localparam logic [2:0] ERR_UNCLOSED    = 3'd5;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [7:0] delimiter;
		logic       strict_en;
		logic       hdr_en;
	} cfg_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] content_byte;
		logic [2:0] error_code;
		logic       in_header;
		logic [7:0] row_fields;
		logic [7:0] col_total;
	} out_item_t;

	typedef struct packed {
		logic [1:0] parse_phase;
		logic       cr_pending;
		logic       field_nonempty;
		logic [7:0] fields_in_row;
		logic [7:0] exp_cols;
		logic       first_row_done;
		logic       error_stuck;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		parse_phase:      PH_START,
		cr_pending:       1'b0,
		field_nonempty:   1'b0,
		fields_in_row:    8'd0,
		exp_cols:         8'd0,
		first_row_done:   1'b0,
		error_stuck:      1'b0
	};

endpackage

[src/cst_regs.sv]
// APB register file: delimiter, strict mode and header flag.
module cst_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cst_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output cst_pkg::cfg_t             cfg
);
	import cst_pkg::*;

	logic [7:0] delimiter_q;
	logic       strict_q;
	logic       headers_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= 8'd44;
			strict_q    <= 1'b0;
			headers_q   <= 1'b0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_DELIMITER: delimiter_q <= pwdata[7:0];
				REG_STRICT:    strict_q    <= pwdata[0];
				REG_HEADERS:   headers_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DELIMITER: prdata = {24'd0, delimiter_q};
			REG_STRICT:    prdata = {31'd0, strict_q};
			REG_HEADERS:   prdata = {31'd0, headers_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg = '{delimiter: delimiter_q, strict_en: strict_q, hdr_en: headers_q};

endmodule

[src/cst_parse.sv]
// Parse state registers and the single-step next-state / result logic.
`include "csv_stream_tokenizer_macros.svh"
module cst_parse #(
	parameter int MAX_FIELDS = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  cst_pkg::cfg_t      cfg,
	input  cst_pkg::in_item_t  item,
	output logic               res_valid,
	output cst_pkg::out_item_t res
);
	import cst_pkg::*;

	localparam logic [7:0] FIELD_CAP = (MAX_FIELDS < 255) ? 8'(MAX_FIELDS) : 8'd255;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_CONTENT = 3'd1;
	localparam logic [2:0] ACT_FIELD   = 3'd2;
	localparam logic [2:0] ACT_ROW     = 3'd3;
	localparam logic [2:0] ACT_ERROR   = 3'd4;

	parse_state_t st_q;
	parse_state_t nx;
	logic [2:0]   act;
	logic [2:0]   err_c;
	logic [7:0]   b;
	logic         is_delim;
	logic         is_brk;
	logic         is_space;
	// row end terms
	logic         er_blank;
	logic         er_hdr;
	logic [7:0]   er_n;
	logic [7:0]   er_exp0;
	logic         er_mis;
	// assertion terms
	logic         stuck_byte;
	logic         caps_ok;
	logic         non_row;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v < FIELD_CAP) ? v + 8'd1 : FIELD_CAP;
	endfunction

	assign b        = item.data_byte;
	assign is_delim = (b == cfg.delimiter);
	assign is_brk   = (b == CH_CR) || (b == CH_LF);
	assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

	assign er_blank = (st_q.fields_in_row == 8'd0) && !st_q.field_nonempty;
	assign er_hdr   = cfg.hdr_en && !st_q.first_row_done;
	assign er_n     = sat_inc(st_q.fields_in_row);
	assign er_exp0  = (st_q.exp_cols == 8'd0) ? er_n : st_q.exp_cols;
	assign er_mis   = cfg.strict_en && (er_n != er_exp0);

	always_comb begin
		nx    = st_q;
		act   = ACT_NONE;
		err_c = ERR_NONE;
		if (item.command) begin
			if (!st_q.error_stuck) begin
				if (st_q.parse_phase == PH_QUOTED) begin
					act   = ACT_ERROR;
					err_c = ERR_UNCLOSED;
				end else if (st_q.parse_phase != PH_START || st_q.fields_in_row != 8'd0) begin
					act = ACT_ROW;
				end
			end
		end else if (!st_q.error_stuck) begin
			nx.cr_pending = 1'b0;
			// LF straight after CR is swallowed
			if (!(st_q.cr_pending && b == CH_LF)) begin
				unique case (st_q.parse_phase)
					PH_START: begin
						if (b == CH_QUOTE) begin
							nx.parse_phase = PH_QUOTED;
						end else if (is_delim) begin
							act = ACT_FIELD;
						end else if (is_brk) begin
							act = ACT_ROW;
						end else begin
							nx.parse_phase = PH_UNQ;
							act = ACT_CONTENT;
						end
					end
					PH_UNQ: begin
						if (b == CH_QUOTE) begin
							if (cfg.strict_en) begin
								act   = ACT_ERROR;
								err_c = ERR_STRAY_QUOTE;
							end else begin
								act = ACT_CONTENT;
							end
						end else if (is_delim) begin
							act = ACT_FIELD;
						end else if (is_brk) begin
							act = ACT_ROW;
						end else begin
							act = ACT_CONTENT;
						end
					end
					PH_QUOTED: begin
						if (b == CH_QUOTE) begin
							nx.parse_phase = PH_AFTER;
						end else begin
							act = ACT_CONTENT;
						end
					end
					PH_AFTER: begin
						if (b == CH_QUOTE) begin
							// doubled quote: literal quote, back inside the field
							nx.parse_phase = PH_QUOTED;
							act = ACT_CONTENT;
						end else if (is_delim) begin
							act = ACT_FIELD;
						end else if (is_brk) begin
							act = ACT_ROW;
						end else if (cfg.strict_en) begin
							act   = ACT_ERROR;
							err_c = ERR_AFTER_QUOTE;
						end else if (!is_space) begin
							nx.parse_phase = PH_UNQ;
							act = ACT_CONTENT;
						end
					end
					default: ;
				endcase
				if (act == ACT_ROW && b == CH_CR) begin
					nx.cr_pending = 1'b1;
				end
			end
		end

		res_valid = 1'b0;
		res       = '0;
		case (act)
			ACT_CONTENT: begin
				nx.field_nonempty = 1'b1;
				res_valid        = 1'b1;
				res.kind         = KIND_CONTENT;
				res.content_byte = b;
			end
			ACT_FIELD: begin
				nx.fields_in_row  = sat_inc(st_q.fields_in_row);
				nx.field_nonempty = 1'b0;
				nx.parse_phase    = PH_START;
				res_valid = 1'b1;
				res.kind  = KIND_FIELD;
			end
			ACT_ERROR: begin
				nx.error_stuck = 1'b1;
				res_valid      = 1'b1;
				res.kind       = KIND_ERROR;
				res.error_code = err_c;
			end
			ACT_ROW: begin
				nx.fields_in_row  = 8'd0;
				nx.field_nonempty = 1'b0;
				nx.parse_phase    = PH_START;
				if (er_blank) begin
					if (cfg.strict_en) begin
						nx.error_stuck = 1'b1;
						res_valid      = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_EMPTY_ROW;
					end
				end else if (er_hdr) begin
					nx.exp_cols       = er_n;
					nx.first_row_done = 1'b1;
					res_valid      = 1'b1;
					res.kind       = KIND_ROW;
					res.row_fields = er_n;
				end else begin
					if (cfg.strict_en) begin
						nx.exp_cols = er_exp0;
					end else begin
						nx.exp_cols = (er_n > er_exp0) ? er_n : er_exp0;
					end
					res_valid = 1'b1;
					if (er_mis) begin
						nx.error_stuck = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_FIELD_COUNT;
					end else begin
						nx.first_row_done = 1'b1;
						res.kind       = KIND_ROW;
						res.row_fields = er_n;
					end
				end
			end
			default: ;
		endcase

		res.in_header = cfg.hdr_en && !st_q.first_row_done;
		res.col_total = nx.exp_cols;

		// end of input drops all parse state
		if (item.command) begin
			nx = STATE_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (step) begin
			st_q <= nx;
		end
	end

	assign stuck_byte = step && st_q.error_stuck && !item.command;
	assign caps_ok    = (st_q.fields_in_row <= FIELD_CAP) && (st_q.exp_cols <= FIELD_CAP);
	assign non_row    = res_valid && (res.kind != KIND_ROW);

	`CST_ASSERT_IMP(a_stuck_quiet, clk, arst_n, stuck_byte, !res_valid)
	`CST_ASSERT_NXT(a_eoi_clears, clk, arst_n, step && item.command, st_q == STATE_RESET)
	`CST_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, caps_ok)
	`CST_ASSERT_IMP(a_rowf_row_only, clk, arst_n, non_row, res.row_fields == 8'd0)

endmodule

[src/csv_stream_tokenizer.sv]
// Top level of the CSV stream tokenizer: input stage, parser, result stage, registers.
// Throughput: one item per cycle sustained, with either side free to idle or stall.
// Path: an item taken in is registered in the input stage, parsed out of it, and its
//   result (if any) is registered in the result stage and offered on result_valid.
// Reset (arst_n low, asynchronous) empties both stages, clears the parse state and
//   loads the register defaults: delimiter 44, strict mode off, headers off.
module csv_stream_tokenizer #(
	parameter int MAX_FIELDS = 255
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cst_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// byte stream in
	input  logic                       item_valid,
	output logic                       item_ready,
	input  cst_pkg::in_item_t          item,
	// tokens out
	output logic                       result_valid,
	input  logic                       result_ready,
	output cst_pkg::out_item_t         result
);
	import cst_pkg::*;

	cfg_t      cfg;
	logic      vld_s1;
	in_item_t  item_s1;
	logic      vld_s2;
	out_item_t res_s2;
	logic      s2_free;
	logic      step;
	logic      res_valid;
	out_item_t res;

	cst_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result stage can take a new token when empty or when its token
	// transfers this cycle; the input stage moves whenever that holds.
	assign s2_free    = !vld_s2 || result_ready;
	assign step       = vld_s1 && s2_free;
	assign item_ready = !vld_s1 || s2_free;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	cst_parse #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cfg       (cfg),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result stage: items that give no token simply leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && step && res_valid) begin
			res_s2 <= res;
		end
	end

	assign result_valid = vld_s2;
	assign result       = res_s2;

endmodule
